// ----- sv/decode_compact_fields_defines.svh -----
// Assertion macros for the compact field decoder.
// Used by decode_compact_fields.sv; expects signals named clock and reset in scope.
`ifndef DECODE_COMPACT_FIELDS_DEFINES_SVH
`define DECODE_COMPACT_FIELDS_DEFINES_SVH

// cond must hold at every clock edge outside reset
`define DCF_ASSERT_ALWAYS(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("decode_compact_fields: invariant violated");

// cons must hold in the same cycle as ante
`define DCF_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("decode_compact_fields: implication violated");

// cons must hold in the cycle after ante
`define DCF_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("decode_compact_fields: next-cycle check violated");

`endif

// ----- sv/dcf_pkg.sv -----
// Package for the compact field decoder: parse phases, field kinds, constants.
// No dependencies; imported by decode_compact_fields.
package dcf_pkg;

   localparam int unsigned VALUE_BYTES = 4;
   localparam int unsigned LEN_W       = 6;

   typedef enum logic [1:0] {
      PH_COUNT   = 2'd0,
      PH_HEADER  = 2'd1,
      PH_PAYLOAD = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      CK_UNS = 2'd0,
      CK_SGN = 2'd1,
      CK_STR = 2'd2,
      CK_ERR = 2'd3
   } cur_kind_type;

   typedef enum logic [2:0] {
      FK_COUNT = 3'd0,
      FK_UNS   = 3'd1,
      FK_SGN   = 3'd2,
      FK_CHAR  = 3'd3,
      FK_EMPTY = 3'd4,
      FK_ERR   = 3'd5
   } field_kind_type;

   localparam logic [7:0] HDR_LAST_BIT = 8'h80;
   localparam logic [7:0] HDR_STR_BIT  = 8'h40;
   localparam logic [7:0] HDR_SGN_BIT  = 8'h20;
   localparam logic [7:0] HDR_STR_LEN  = 8'h3F;
   localparam logic [7:0] HDR_INT_LEN  = 8'h1F;

endpackage

// ----- sv/decode_compact_fields.sv -----
// Compact record stream decoder, one byte per transfer.
// Depends on dcf_pkg and decode_compact_fields_defines.svh.
//
// Usage:
//   req_ channel: one stream byte per transfer (req_in_byte). The first byte of
//   a record is a struct count; then each field is a header byte and payload.
//   rsp_ channel: zero or one result per input byte: field kind, 32-bit value
//   and end-of-field / end-of-struct / end-of-record flags.
// Registered: a result appears on rsp_ in the cycle after its byte is accepted.
// Throughput: one byte per cycle while req_ready is high. The parse state and
//   the result register update in the same cycle; the next byte can follow.
// Stall: the result register holds a result until it is taken; req_ready stays
//   high while the register is empty or is being emptied in the same cycle, and
//   drops only when a result waits and rsp_ready is low.
// Reset: synchronous, active high; the decoder then expects a record count and
//   the result register is empty.
// Integer fields longer than VALUE_BYTES skip their payload and end with a
//   length-error result.
`include "decode_compact_fields_defines.svh"

module decode_compact_fields
   import dcf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_field_kind,
   output logic [31:0] rsp_value,
   output logic        rsp_last_of_field,
   output logic        rsp_last_of_struct,
   output logic        rsp_last_of_record
);

   phase_type        phase_ff, phase_in;
   logic [7:0]       structs_left_ff, structs_left_in;
   cur_kind_type     cur_kind_ff, cur_kind_in;
   logic [LEN_W-1:0] payload_left_ff, payload_left_in;
   logic [LEN_W-1:0] payload_total_ff, payload_total_in;
   logic [31:0]      gathered_ff, gathered_in;
   logic             field_is_last_ff, field_is_last_in;

   logic             rsp_valid_ff, rsp_valid_in;
   field_kind_type   rsp_kind_ff;
   logic [31:0]      rsp_value_ff;
   logic             rsp_lf_ff, rsp_ls_ff, rsp_lr_ff;

   logic             accept;
   logic             emit, end_fld;
   field_kind_type   o_kind;
   logic [31:0]      o_value;
   logic             o_lf, o_ls, o_lr;
   logic [LEN_W-1:0] str_len, int_len, left_dec;
   logic [31:0]      gathered_shift, int_result;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign str_len        = LEN_W'(req_in_byte & HDR_STR_LEN);
   assign int_len        = LEN_W'(req_in_byte & HDR_INT_LEN);
   assign left_dec       = payload_left_ff - LEN_W'(1);
   assign gathered_shift = {gathered_ff[23:0], req_in_byte};

   always_comb begin
      int_result = gathered_shift;
      if (cur_kind_ff == CK_SGN) begin
         case (payload_total_ff)
            LEN_W'(1): int_result = {{24{gathered_shift[7]}}, gathered_shift[7:0]};
            LEN_W'(2): int_result = {{16{gathered_shift[15]}}, gathered_shift[15:0]};
            LEN_W'(3): int_result = {{8{gathered_shift[23]}}, gathered_shift[23:0]};
            default:   int_result = gathered_shift;
         endcase
      end
   end

   // datapath and result
   always_comb begin
      structs_left_in  = structs_left_ff;
      cur_kind_in      = cur_kind_ff;
      payload_left_in  = payload_left_ff;
      payload_total_in = payload_total_ff;
      gathered_in      = gathered_ff;
      field_is_last_in = field_is_last_ff;
      emit    = 1'b0;
      end_fld = 1'b0;
      o_kind  = FK_COUNT;
      o_value = '0;
      o_lf    = 1'b0;
      o_ls    = 1'b0;
      o_lr    = 1'b0;
      unique case (phase_ff)
         PH_HEADER: begin
            field_is_last_in = (req_in_byte & HDR_LAST_BIT) != 8'h00;
            gathered_in      = '0;
            if ((req_in_byte & HDR_STR_BIT) != 8'h00) begin
               cur_kind_in      = CK_STR;
               payload_total_in = str_len;
               payload_left_in  = str_len;
               if (str_len == '0) begin
                  emit    = 1'b1;
                  end_fld = 1'b1;
                  o_kind  = FK_EMPTY;
               end
            end else begin
               cur_kind_in = ((req_in_byte & HDR_SGN_BIT) != 8'h00) ? CK_SGN : CK_UNS;
               if (int_len > LEN_W'(VALUE_BYTES)) begin
                  cur_kind_in = CK_ERR;
               end
               payload_total_in = int_len;
               payload_left_in  = int_len;
               if (int_len == '0) begin
                  emit    = 1'b1;
                  end_fld = 1'b1;
                  o_kind  = ((req_in_byte & HDR_SGN_BIT) != 8'h00) ? FK_SGN : FK_UNS;
               end
            end
         end
         PH_PAYLOAD: begin
            payload_left_in = left_dec;
            case (cur_kind_ff)
               CK_STR: begin
                  emit    = 1'b1;
                  end_fld = (left_dec == '0);
                  o_kind  = FK_CHAR;
                  o_value = {24'h000000, req_in_byte};
               end
               CK_ERR: begin
                  if (left_dec == '0) begin
                     emit    = 1'b1;
                     end_fld = 1'b1;
                     o_kind  = FK_ERR;
                  end
               end
               default: begin
                  gathered_in = gathered_shift;
                  if (left_dec == '0) begin
                     emit    = 1'b1;
                     end_fld = 1'b1;
                     o_kind  = (cur_kind_ff == CK_SGN) ? FK_SGN : FK_UNS;
                     o_value = int_result;
                  end
               end
            endcase
         end
         default: begin
            structs_left_in = req_in_byte;
            emit    = 1'b1;
            o_kind  = FK_COUNT;
            o_value = {24'h000000, req_in_byte};
            o_lr    = (req_in_byte == 8'h00);
         end
      endcase
      if (end_fld) begin
         o_lf = 1'b1;
         o_ls = field_is_last_in;
         if (field_is_last_in) begin
            structs_left_in = structs_left_ff - 8'd1;
            o_lr            = (structs_left_ff == 8'd1);
         end
      end
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (end_fld) begin
         phase_in = o_lr ? PH_COUNT : PH_HEADER;
      end else begin
         unique case (phase_ff)
            PH_HEADER:  phase_in = PH_PAYLOAD;
            PH_PAYLOAD: phase_in = PH_PAYLOAD;
            default:    phase_in = o_lr ? PH_COUNT : PH_HEADER;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (accept && emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_COUNT;
         structs_left_ff  <= '0;
         cur_kind_ff      <= CK_UNS;
         payload_left_ff  <= '0;
         payload_total_ff <= '0;
         field_is_last_ff <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            phase_ff         <= phase_in;
            structs_left_ff  <= structs_left_in;
            cur_kind_ff      <= cur_kind_in;
            payload_left_ff  <= payload_left_in;
            payload_total_ff <= payload_total_in;
            field_is_last_ff <= field_is_last_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         gathered_ff <= gathered_in;
      end
      if (accept && emit) begin
         rsp_kind_ff  <= o_kind;
         rsp_value_ff <= o_value;
         rsp_lf_ff    <= o_lf;
         rsp_ls_ff    <= o_ls;
         rsp_lr_ff    <= o_lr;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_field_kind     = rsp_kind_ff;
   assign rsp_value          = rsp_value_ff;
   assign rsp_last_of_field  = rsp_lf_ff;
   assign rsp_last_of_struct = rsp_ls_ff;
   assign rsp_last_of_record = rsp_lr_ff;

   `DCF_ASSERT_IMPLY(a_count_not_field_end, rsp_valid_ff && rsp_kind_ff == FK_COUNT, !rsp_lf_ff)
   `DCF_ASSERT_IMPLY(a_struct_end_is_field_end, rsp_valid_ff && rsp_ls_ff, rsp_lf_ff)
   `DCF_ASSERT_IMPLY(a_record_end_kind, rsp_valid_ff && rsp_lr_ff,
                     rsp_ls_ff || rsp_kind_ff == FK_COUNT)
   `DCF_ASSERT_ALWAYS(a_payload_nonempty, phase_ff != PH_PAYLOAD || payload_left_ff != '0)
   `DCF_ASSERT_NEXT(a_record_end_to_count, accept && emit && o_lr, phase_ff == PH_COUNT)

endmodule

// ----- tb/decode_compact_fields_tb.sv -----
// Testbench for decode_compact_fields: drives compact record byte streams and checks
// every decoded result against an internal parse of the same stream.
// Depends on dcf_pkg and the decode_compact_fields RTL.
module decode_compact_fields_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import dcf_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   typedef struct {
      field_kind_type kind;
      logic [31:0]    value;
      logic           end_field;
      logic           end_struct;
      logic           end_record;
   } decoded_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_in_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_field_kind;
   logic [31:0] rsp_value;
   logic        rsp_last_of_field;
   logic        rsp_last_of_struct;
   logic        rsp_last_of_record;

   decoded_result_type pending_results[$];
   int          mismatch_count = 0;
   int          cycle_count = 0;
   int          bytes_sent = 0;
   logic        idle_on = 1'b1;
   int          rsp_hold_cycles = 0;
   int          ready_wait = 0;

   phase_type    parse_phase = PH_COUNT;
   logic [7:0]   structs_left = 8'h00;
   cur_kind_type field_class = CK_UNS;
   logic [5:0]   payload_left = 6'd0;
   logic [5:0]   payload_total = 6'd0;
   logic [31:0]  gathered_value = 32'h0;
   logic         field_is_last = 1'b0;

   decode_compact_fields dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_in_byte        (req_in_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_field_kind     (rsp_field_kind),
      .rsp_value          (rsp_value),
      .rsp_last_of_field  (rsp_last_of_field),
      .rsp_last_of_struct (rsp_last_of_struct),
      .rsp_last_of_record (rsp_last_of_record)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatch_count < 40)
         $display("mismatch: %s got %0h want %0h (cycle %0d)", what, got, want, cycle_count);
      mismatch_count++;
   endtask

   task automatic push_result(input field_kind_type kind, input logic [31:0] value,
                              input logic lf, input logic ls, input logic lr);
      decoded_result_type r;
      r.kind       = kind;
      r.value      = value;
      r.end_field  = lf;
      r.end_struct = ls;
      r.end_record = lr;
      pending_results.push_back(r);
   endtask

   task automatic close_field(input field_kind_type kind, input logic [31:0] value);
      logic rec_done;
      rec_done    = 1'b0;
      parse_phase = PH_HEADER;
      if (field_is_last) begin
         structs_left = structs_left - 8'd1;
         if (structs_left == 8'd0) begin
            rec_done    = 1'b1;
            parse_phase = PH_COUNT;
         end
      end
      push_result(kind, value, 1'b1, field_is_last, rec_done);
   endtask

   function automatic logic [31:0] extend_integer();
      int          bits;
      logic [31:0] v;
      logic [31:0] mask;
      v = gathered_value;
      if (field_class == CK_SGN && payload_total > 0 && payload_total < 4) begin
         bits = payload_total * 8;
         mask = (32'h1 << bits) - 32'h1;
         v    = v & mask;
         if (v[bits-1])
            v = v | ~mask;
      end
      return v;
   endfunction

   task automatic decode_byte(input logic [7:0] b);
      logic [5:0] len;
      case (parse_phase)
         PH_HEADER: begin
            field_is_last  = b[7];
            gathered_value = 32'h0;
            if ((b & HDR_STR_BIT) != 8'h00) begin
               len         = 6'(b & HDR_STR_LEN);
               field_class = CK_STR;
            end else begin
               len         = 6'(b & HDR_INT_LEN);
               field_class = ((b & HDR_SGN_BIT) != 8'h00) ? CK_SGN : CK_UNS;
               if (len > VALUE_BYTES)
                  field_class = CK_ERR;
            end
            payload_total = len;
            payload_left  = len;
            if (len != 6'd0)
               parse_phase = PH_PAYLOAD;
            else if ((b & HDR_STR_BIT) != 8'h00)
               close_field(FK_EMPTY, 32'h0);
            else
               close_field(((b & HDR_SGN_BIT) != 8'h00) ? FK_SGN : FK_UNS, 32'h0);
         end
         PH_PAYLOAD: begin
            payload_left = payload_left - 6'd1;
            if (field_class == CK_STR) begin
               if (payload_left == 6'd0)
                  close_field(FK_CHAR, {24'h0, b});
               else
                  push_result(FK_CHAR, {24'h0, b}, 1'b0, 1'b0, 1'b0);
            end else if (field_class == CK_ERR) begin
               if (payload_left == 6'd0)
                  close_field(FK_ERR, 32'h0);
            end else begin
               gathered_value = {gathered_value[23:0], b};
               if (payload_left == 6'd0)
                  close_field((field_class == CK_SGN) ? FK_SGN : FK_UNS, extend_integer());
            end
         end
         default: begin
            structs_left = b;
            parse_phase  = (b == 8'h00) ? PH_COUNT : PH_HEADER;
            push_result(FK_COUNT, {24'h0, b}, 1'b0, 1'b0, b == 8'h00);
         end
      endcase
   endtask

   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = idle_on ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      do @(posedge clock); while (!(req_valid && req_ready));
      decode_byte(b);
      bytes_sent++;
   endtask

   function automatic logic [7:0] payload_byte();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         2: return 8'h80;
         3: return 8'h7F;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic send_random_field(input logic last);
      int   sel;
      int   len;
      logic sgn;
      sel = $urandom_range(0, 99);
      if (sel < 40) begin
         sel = $urandom_range(0, 99);
         if (sel < 10) len = 0;
         else if (sel < 88) len = $urandom_range(1, 4);
         else len = $urandom_range(5, 63);
         send_byte({last, 1'b1, 6'(len)});
      end else begin
         if (sel < 88) len = $urandom_range(0, 4);
         else if (sel < 97) len = $urandom_range(5, 8);
         else len = $urandom_range(9, 31);
         sgn = $urandom_range(0, 1);
         send_byte({last, 1'b0, sgn, 5'(len)});
      end
      repeat (len) send_byte(payload_byte());
   endtask

   task automatic send_record(input int structs);
      int nf;
      send_byte(8'(structs));
      repeat (structs) begin
         nf = $urandom_range(1, 3);
         for (int f = 0; f < nf; f++)
            send_random_field(f == nf - 1);
      end
   endtask

   // bring the parse back to a record boundary
   task automatic finish_record();
      while (parse_phase != PH_COUNT) begin
         if (parse_phase == PH_PAYLOAD)
            send_byte(8'($urandom));
         else
            send_byte(HDR_LAST_BIT | (($urandom_range(0, 1) == 1) ? HDR_STR_BIT : 8'h00));
      end
   endtask

   task automatic test_directed();
      logic [7:0] stream [0:28] = '{
         8'h00, 8'h03,
         8'h40, 8'h42, 8'h41, 8'hFF,
         8'h00, 8'h21, 8'h80,
         8'hA2, 8'h80, 8'h00,
         8'h24, 8'h80, 8'h00, 8'h00, 8'h01,
         8'h25, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05,
         8'hA0,
         8'h84, 8'h12, 8'h34, 8'h56, 8'h78
      };
      foreach (stream[i])
         send_byte(stream[i]);
   endtask

   task automatic test_max_count();
      send_byte(8'hFF);
      for (int i = 0; i < 255; i++)
         send_byte(HDR_LAST_BIT | ((i % 2 == 1) ? HDR_STR_BIT : 8'h00));
   endtask

   task automatic test_backpressure();
      finish_record();
      rsp_hold_cycles = 60;
      send_byte(8'h01);
      send_byte(HDR_LAST_BIT | HDR_STR_BIT | 8'd20);
      repeat (20) send_byte(payload_byte());
   endtask

   task automatic test_random_stream(input int n_bytes);
      int target;
      int sel;
      finish_record();
      target = bytes_sent + n_bytes;
      while (bytes_sent < target) begin
         sel = $urandom_range(0, 99);
         if (sel < 88) begin
            sel = $urandom_range(0, 99);
            if (sel < 8) send_record(0);
            else if (sel < 92) send_record($urandom_range(1, 3));
            else send_record($urandom_range(4, 12));
         end else if (sel < 94) begin
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
            finish_record();
         end else begin
            send_byte(8'($urandom_range(1, 3)));
            send_byte(8'($urandom));
            repeat ($urandom_range(0, 3)) send_byte(8'($urandom));
            finish_record();
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         ready_wait = 0;
      end else if (rsp_hold_cycles > 0) begin
         rsp_hold_cycles--;
         rsp_ready <= 1'b0;
      end else if (ready_wait > 0) begin
         ready_wait--;
         rsp_ready <= 1'b0;
      end else if (rsp_valid && rsp_ready) begin
         ready_wait = idle_on ? $urandom_range(0, 4) : 0;
         rsp_ready <= (ready_wait == 0);
         if (ready_wait > 0)
            ready_wait--;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_results
      decoded_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result, value", rsp_value, 32'h0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_field_kind !== want.kind)
               report_mismatch("field_kind", 32'(rsp_field_kind), 32'(want.kind));
            if (rsp_value !== want.value)
               report_mismatch("value", rsp_value, want.value);
            if (rsp_last_of_field !== want.end_field)
               report_mismatch("last_of_field", 32'(rsp_last_of_field), 32'(want.end_field));
            if (rsp_last_of_struct !== want.end_struct)
               report_mismatch("last_of_struct", 32'(rsp_last_of_struct),
                               32'(want.end_struct));
            if (rsp_last_of_record !== want.end_record)
               report_mismatch("last_of_record", 32'(rsp_last_of_record),
                               32'(want.end_record));
         end
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      idle_on = 1'b1;
      test_directed();
      idle_on = 1'b0;
      test_max_count();
      test_backpressure();
      idle_on = 1'b1;
      test_random_stream(500);
      idle_on = 1'b0;
      test_random_stream(200);
      idle_on = 1'b1;
      test_random_stream(300);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/dcf_pkg.sv
sv/decode_compact_fields.sv
tb/decode_compact_fields_tb.sv
